[design/bga_pkg.sv]
// ----------------------------------------------------------------------------
// bga_pkg: shared types and constants for the battery gauge averager
// Field widths, register map, discharge curve table and interface structs.
// ----------------------------------------------------------------------------
package bga_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int MV_W       = 16;
    localparam int PCT_W      = 7;
    localparam int RATIO_W    = 16;
    localparam int FRAC_W     = 12;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam int CURVE_SEGS = 12;
    localparam int SEG_W      = 4;
    localparam int SPAN_W     = 7;
    localparam int STEP_PCT_W = 4;
    localparam int INTERP_W   = 12;

    localparam logic [1:0] REG_DIVIDER_RATIO    = 2'd0;
    localparam logic [1:0] REG_LOW_PERCENT      = 2'd1;
    localparam logic [1:0] REG_CRITICAL_PERCENT = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_RESET    = 16'd8192;
    localparam logic [PCT_W-1:0]   LOW_RESET      = 7'd20;
    localparam logic [PCT_W-1:0]   CRITICAL_RESET = 7'd8;

    localparam logic [MV_W-1:0]  CURVE_TOP_MV = 16'd4200;
    localparam logic [MV_W-1:0]  CURVE_BOT_MV = 16'd3200;
    localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY    = 7'd0;

    typedef struct packed {
        logic [RATIO_W-1:0] divider_ratio;
        logic [PCT_W-1:0]   low_percent;
        logic [PCT_W-1:0]   critical_percent;
    } bga_cfg_t;

    typedef struct packed {
        logic [MV_W-1:0]  battery_mv;
        logic [PCT_W-1:0] charge_percent;
        logic             low_flag;
        logic             critical_flag;
    } bga_result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } bga_status_t;

    function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
        logic [MV_W-1:0] mv;
        case (idx)
            4'd0:    mv = 16'd4200;
            4'd1:    mv = 16'd4100;
            4'd2:    mv = 16'd4000;
            4'd3:    mv = 16'd3900;
            4'd4:    mv = 16'd3800;
            4'd5:    mv = 16'd3750;
            4'd6:    mv = 16'd3700;
            4'd7:    mv = 16'd3650;
            4'd8:    mv = 16'd3600;
            4'd9:    mv = 16'd3500;
            4'd10:   mv = 16'd3400;
            4'd11:   mv = 16'd3300;
            default: mv = 16'd3200;
        endcase
        return mv;
    endfunction

    function automatic logic [PCT_W-1:0] curve_pct(input logic [SEG_W-1:0] idx);
        logic [PCT_W-1:0] pct;
        case (idx)
            4'd0:    pct = 7'd100;
            4'd1:    pct = 7'd92;
            4'd2:    pct = 7'd82;
            4'd3:    pct = 7'd70;
            4'd4:    pct = 7'd56;
            4'd5:    pct = 7'd48;
            4'd6:    pct = 7'd38;
            4'd7:    pct = 7'd28;
            4'd8:    pct = 7'd18;
            4'd9:    pct = 7'd9;
            4'd10:   pct = 7'd4;
            4'd11:   pct = 7'd1;
            default: pct = 7'd0;
        endcase
        return pct;
    endfunction

endpackage

[design/battery_gauge_averager.sv]
// ----------------------------------------------------------------------------
// battery_gauge_averager: battery voltage and state-of-charge gauge
// Averages ADC pin samples and reports battery mV, charge percent and flags.
// ----------------------------------------------------------------------------
// Each accepted sample transaction is summed. The transaction that
// completes a group of SAMPLES_PER_READING samples starts a reading, and the
// input stays not ready while it is computed: a shift-add multiply by the
// divider ratio on one shared adder, a reciprocal multiply for the division
// by SAMPLES_PER_READING, a curve lookup, a restoring divide for the
// interpolated percent (skipped at the ends of the curve) and a final step
// that hands the result to the output register. The input stays busy longer
// while a previous result still waits in the output register; a finished
// result waits there while the next group is summed.
module battery_gauge_averager #(
    parameter int SAMPLES_PER_READING = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bga_pkg::SAMPLE_W-1:0]  s_sample_mv,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bga_pkg::MV_W-1:0]      m_battery_mv,
    output logic [bga_pkg::PCT_W-1:0]     m_charge_percent,
    output logic                          m_low_flag,
    output logic                          m_critical_flag,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bga_pkg::ADDR_W-1:0]    paddr,
    input  logic [bga_pkg::DATA_W-1:0]    pwdata,
    output logic [bga_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import bga_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_READING);
    localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READING - 1);

    bga_cfg_t    cfg;
    bga_status_t status;
    bga_result_t seq_result;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    bga_result_t      res_reg, res_next;

    logic [SUM_W-1:0] sum_total;
    logic             s_accept;
    logic             last;
    logic             start;
    logic             out_free;

    bga_apb u_bga_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bga_seq #(
        .SUM_W (SUM_W),
        .NS    (SAMPLES_PER_READING)
    ) u_bga_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .sum_in   (sum_total),
        .cfg      (cfg),
        .out_free (out_free),
        .status   (status),
        .result   (seq_result)
    );

    assign s_ready   = status.idle;
    assign s_accept  = s_valid & s_ready;
    assign sum_total = sum_reg + SUM_W'(s_sample_mv);
    assign last      = (cnt_reg == CNT_LAST);
    assign start     = s_accept & last;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (s_accept) begin
            if (last) begin
                sum_next = '0;
                cnt_next = '0;
            end else begin
                sum_next = sum_total;
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (status.done) begin
            m_valid_next = 1'b1;
            res_next     = seq_result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_battery_mv     = res_reg.battery_mv;
    assign m_charge_percent = res_reg.charge_percent;
    assign m_low_flag       = res_reg.low_flag;
    assign m_critical_flag  = res_reg.critical_flag;

endmodule

[design/bga_alu.sv]
// ----------------------------------------------------------------------------
// bga_alu: shared adder/subtractor
// One add or subtract per cycle with carry out; carry high on subtract means
// no borrow.
// ----------------------------------------------------------------------------
module bga_alu #(
    parameter int W = 32
) (
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    input  logic         sub,
    output logic [W-1:0] result,
    output logic         carry
);

    logic [W-1:0] op_b_eff;
    logic [W:0]   total;

    assign op_b_eff = sub ? ~op_b : op_b;
    assign total    = {1'b0, op_a} + {1'b0, op_b_eff} + {{W{1'b0}}, sub};
    assign result   = total[W-1:0];
    assign carry    = total[W];

endmodule

[design/bga_apb.sv]
// ----------------------------------------------------------------------------
// bga_apb: configuration register file
// APB-style write/read access to divider ratio and flag thresholds.
// ----------------------------------------------------------------------------
module bga_apb (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bga_pkg::ADDR_W-1:0]  paddr,
    input  logic [bga_pkg::DATA_W-1:0]  pwdata,
    output logic [bga_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output bga_pkg::bga_cfg_t           cfg
);
    import bga_pkg::*;

    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [PCT_W-1:0]   low_reg, low_next;
    logic [PCT_W-1:0]   crit_reg, crit_next;
    logic [1:0]         reg_idx;
    logic               wr_en;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    always_comb begin
        ratio_next = ratio_reg;
        low_next   = low_reg;
        crit_next  = crit_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_DIVIDER_RATIO:    ratio_next = pwdata[RATIO_W-1:0];
                REG_LOW_PERCENT:      low_next   = pwdata[PCT_W-1:0];
                REG_CRITICAL_PERCENT: crit_next  = pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= RATIO_RESET;
            low_reg   <= LOW_RESET;
            crit_reg  <= CRITICAL_RESET;
        end else begin
            ratio_reg <= ratio_next;
            low_reg   <= low_next;
            crit_reg  <= crit_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DIVIDER_RATIO:    prdata = {{(DATA_W-RATIO_W){1'b0}}, ratio_reg};
            REG_LOW_PERCENT:      prdata = {{(DATA_W-PCT_W){1'b0}}, low_reg};
            REG_CRITICAL_PERCENT: prdata = {{(DATA_W-PCT_W){1'b0}}, crit_reg};
            default:              prdata = '0;
        endcase
    end

    assign cfg.divider_ratio    = ratio_reg;
    assign cfg.low_percent      = low_reg;
    assign cfg.critical_percent = crit_reg;

endmodule

[design/bga_seq.sv]
// ----------------------------------------------------------------------------
// bga_seq: reading sequencer
// Shift-add multiply on one adder, reciprocal multiply for the voltage average,
// curve lookup and a restoring divide for the interpolated percentage, skipped at the curve ends.
// ----------------------------------------------------------------------------
module bga_seq #(
    parameter int SUM_W = 16,
    parameter int NS    = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [SUM_W-1:0]     sum_in,
    input  bga_pkg::bga_cfg_t    cfg,
    input  logic                 out_free,
    output bga_pkg::bga_status_t status,
    output bga_pkg::bga_result_t result
);
    import bga_pkg::*;

    localparam int PW     = SUM_W + RATIO_W + 1;
    localparam int XW     = PW - FRAC_W;
    localparam int DVW    = ($clog2(NS + 1) > 8) ? $clog2(NS + 1) : 8;
    localparam int RW     = DVW + 1;
    localparam int STEP_W = $clog2(XW);
    localparam int RK     = XW + $clog2(NS);
    localparam logic [PW-1:0] ROUND_HALF = PW'(NS) << (FRAC_W - 1);
    localparam logic [63:0] RCP_FULL = ((64'd1 << RK) + 64'(NS) - 64'd1) / 64'(NS);
    localparam logic [XW:0] RCP = RCP_FULL[XW:0];

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIVV = 3'd2;
    localparam logic [2:0] ST_PCT  = 3'd3;
    localparam logic [2:0] ST_DIVP = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [PW-1:0]      acc_reg, acc_next;
    logic [PW-1:0]      mcand_reg, mcand_next;
    logic [RATIO_W-1:0] mplier_reg, mplier_next;
    logic [XW-1:0]      quo_reg, quo_next;
    logic [DVW-1:0]     rem_reg, rem_next;
    logic [DVW-1:0]     dvs_reg, dvs_next;
    logic [MV_W-1:0]    bat_reg, bat_next;
    logic [PCT_W-1:0]   pct_reg, pct_next;
    logic [PCT_W-1:0]   plo_reg, plo_next;

    logic [PW-1:0]      alu_a, alu_b, alu_res;
    logic               alu_sub, alu_carry;
    logic [RW-1:0]      trial;
    logic [DVW-1:0]     rem_step;
    logic [XW-1:0]      quo_step;
    logic [2*XW:0]      vmul;

    logic [MV_W-1:0]       bat_sat;
    logic [SEG_W-1:0]      seg;
    logic [SEG_W-1:0]      seg_lo;
    logic [MV_W-1:0]       seg_lo_mv;
    logic [SPAN_W-1:0]     seg_den;
    logic [SPAN_W-1:0]     seg_off;
    logic [PCT_W-1:0]      seg_dp;
    logic [INTERP_W-2:0]   interp_num;
    logic [INTERP_W-1:0]   interp_dividend;
    logic                  at_top, at_bot;

    bga_alu #(.W(PW)) u_bga_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .sub    (alu_sub),
        .result (alu_res),
        .carry  (alu_carry)
    );

    assign trial    = {rem_reg, quo_reg[XW-1]};
    assign alu_sub  = (state_reg != ST_MUL);
    assign alu_a    = (state_reg == ST_MUL) ? acc_reg : PW'(trial);
    assign alu_b    = (state_reg == ST_MUL) ? (mplier_reg[0] ? mcand_reg : '0)
                                            : PW'(dvs_reg);
    assign rem_step = alu_carry ? alu_res[DVW-1:0] : trial[DVW-1:0];
    assign quo_step = {quo_reg[XW-2:0], alu_carry};
    assign vmul     = (2*XW+1)'(quo_reg) * (2*XW+1)'(RCP);

    assign bat_sat = (|quo_reg[XW-1:MV_W]) ? {MV_W{1'b1}} : quo_reg[MV_W-1:0];
    assign at_top  = (bat_sat >= CURVE_TOP_MV);
    assign at_bot  = (bat_sat <= CURVE_BOT_MV);

    always_comb begin
        seg = '0;
        for (int i = 0; i < CURVE_SEGS; i++) begin
            if (bat_sat <= curve_mv(SEG_W'(i)) && bat_sat > curve_mv(SEG_W'(i + 1))) begin
                seg = SEG_W'(i);
            end
        end
    end

    assign seg_lo          = seg + 4'd1;
    assign seg_lo_mv       = curve_mv(seg_lo);
    assign seg_den         = SPAN_W'(curve_mv(seg) - seg_lo_mv);
    assign seg_off         = SPAN_W'(bat_sat - seg_lo_mv);
    assign seg_dp          = curve_pct(seg) - curve_pct(seg_lo);
    assign interp_num      = (INTERP_W-1)'(seg_off) * (INTERP_W-1)'(seg_dp[STEP_PCT_W-1:0]);
    assign interp_dividend = {interp_num, 1'b0} + INTERP_W'(seg_den);

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        bat_next    = bat_reg;
        pct_next    = pct_reg;
        plo_next    = plo_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    acc_next    = ROUND_HALF;
                    mcand_next  = PW'(sum_in);
                    mplier_next = cfg.divider_ratio;
                    step_next   = STEP_W'(RATIO_W - 1);
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                acc_next    = alu_res;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - 1'b1;
                if (step_reg == '0) begin
                    quo_next   = alu_res[PW-1:FRAC_W];
                    state_next = ST_DIVV;
                end
            end
            ST_DIVV: begin
                quo_next   = XW'(vmul >> RK);
                state_next = ST_PCT;
            end
            ST_PCT: begin
                bat_next = bat_sat;
                if (at_top) begin
                    pct_next   = PCT_FULL;
                    state_next = ST_FIN;
                end else if (at_bot) begin
                    pct_next   = PCT_EMPTY;
                    state_next = ST_FIN;
                end else begin
                    quo_next   = XW'(interp_dividend);
                    rem_next   = '0;
                    dvs_next   = DVW'({seg_den, 1'b0});
                    plo_next   = curve_pct(seg_lo);
                    step_next  = STEP_W'(XW - 1);
                    state_next = ST_DIVP;
                end
            end
            ST_DIVP: begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    pct_next   = plo_reg + quo_step[PCT_W-1:0];
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        bat_reg    <= bat_next;
        pct_reg    <= pct_next;
        plo_reg    <= plo_next;
    end

    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_FIN) && out_free;

    assign result.battery_mv     = bat_reg;
    assign result.charge_percent = pct_reg;
    assign result.low_flag       = (pct_reg <= cfg.low_percent);
    assign result.critical_flag  = (pct_reg <= cfg.critical_percent);

endmodule

[design/bga_checker.sv]
// ----------------------------------------------------------------------------
// bga_checker: port-level checks for the battery gauge averager
// Result channel behavior and curve limits, bound to the top level.
// ----------------------------------------------------------------------------
module bga_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [bga_pkg::MV_W-1:0]   m_battery_mv,
    input logic [bga_pkg::PCT_W-1:0]  m_charge_percent,
    input logic                       m_low_flag,
    input logic                       m_critical_flag
);
    import bga_pkg::*;

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_battery_mv)
            && $stable(m_charge_percent) && $stable(m_low_flag)
            && $stable(m_critical_flag))
        else $error("result changed while stalled");

    a_valid_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown(m_valid))
        else $error("result valid unknown out of reset");

    a_percent_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_charge_percent <= PCT_FULL)
        else $error("charge percent above full");

    a_curve_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_battery_mv < CURVE_TOP_MV || m_charge_percent == PCT_FULL)
            && (m_battery_mv > CURVE_BOT_MV || m_charge_percent == PCT_EMPTY))
        else $error("curve end percent wrong");

endmodule

bind battery_gauge_averager bga_checker u_bga_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_battery_mv     (m_battery_mv),
    .m_charge_percent (m_charge_percent),
    .m_low_flag       (m_low_flag),
    .m_critical_flag  (m_critical_flag)
);
